FILE: hdl/line_command_framer_macros.svh
// Assertion macros used by the line command framer back end.
// Expects clk_i and rst_ni in the scope of each use.
`ifndef LINE_COMMAND_FRAMER_MACROS_SVH
`define LINE_COMMAND_FRAMER_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define LCF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset.
`define LCF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/lcf_pkg.sv
// Shared types and constants of the line command framer.
// No dependencies.
package lcf_pkg;

  localparam logic [7:0] CH_BS       = 8'h08;
  localparam logic [7:0] CH_LF       = 8'h0A;
  localparam logic [7:0] CH_CR       = 8'h0D;
  localparam logic [7:0] CH_SPACE    = 8'h20;
  localparam logic [7:0] CH_PRINT_LO = 8'h20;
  localparam logic [7:0] CH_PRINT_HI = 8'h7E;

  localparam logic KIND_CHAR     = 1'b0;
  localparam logic KIND_OVERFLOW = 1'b1;

  typedef enum logic [1:0] {
    OP_BYTE,
    OP_BYTE_SCAN,
    OP_TICK
  } op_e;

  typedef struct packed {
    op_e        op;
    logic       is_term;
    logic [7:0] data;
  } cmd_t;

  // front-to-back queue head
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } qhead_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SCAN_RD,
    ST_SCAN_EV,
    ST_SKIP_RD,
    ST_SKIP_EV,
    ST_FIN,
    ST_EMIT_RD,
    ST_EMIT_OUT
  } state_e;

  function automatic logic is_term(input logic [7:0] b);
    return (b == CH_CR) || (b == CH_LF);
  endfunction

endpackage

FILE: hdl/line_command_framer.sv
// Line command framer top level: front queue plus scan/emit back end.
// Depends on lcf_pkg, lcf_front and lcf_back.
//
// Usage:
//  - Input channel (in_valid_i / in_stall_o): cmd_i=0 carries a received byte in
//    data_i, chunk_end_i=1 marks the last byte of a chunk; cmd_i=1 is a pulse tick.
//  - Output channel (out_valid_o / out_stall_i): command characters (kind_o=0),
//    last_o on the final one, or one overflow beat (kind_o=1, ch_o=0, last_o=1)
//    after which every input is dropped.
//  - A 2-entry queue sits between front and back, so input can still be taken
//    while the back end scans or emits, until the queue fills.
//  - Byte beat: passes through the queue and is then written to the byte FIFO;
//    one byte per cycle while the back end is idle.
//  - Line release: a check step, a read and an evaluate step per byte (line,
//    terminator and each further CR/LF), an end to the CR/LF skip, an update
//    step, then a read and an output step per character emitted from the line buffer.
//  - Receiver stall holds the output register; the back end waits on it.
//  - Reset clears counters and flags; FIFO and line buffer contents are not cleared.
module line_command_framer import lcf_pkg::*; #(
  parameter int FIFO_DEPTH = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       cmd_i,
  input  logic [7:0] data_i,
  input  logic       chunk_end_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       kind_o,
  output logic [7:0] ch_o,
  output logic       last_o
);

  qhead_t q_head;
  logic   q_pop;

  lcf_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .cmd_i       (cmd_i),
    .data_i      (data_i),
    .chunk_end_i (chunk_end_i),
    .q_o         (q_head),
    .q_pop_i     (q_pop)
  );

  lcf_back #(
    .FIFO_DEPTH (FIFO_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_i         (q_head),
    .q_pop_o     (q_pop),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .kind_o      (kind_o),
    .ch_o        (ch_o),
    .last_o      (last_o)
  );

endmodule

FILE: hdl/lcf_front.sv
// Front end: accepts input beats, classifies them and queues them (2 entries).
// Depends on lcf_pkg.
module lcf_front import lcf_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       cmd_i,
  input  logic [7:0] data_i,
  input  logic       chunk_end_i,
  output qhead_t     q_o,
  input  logic       q_pop_i
);

  cmd_t       ent_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  cmd_t       cls;
  logic       push;

  always_comb begin
    cls.data    = data_i;
    cls.is_term = is_term(data_i);
    if (cmd_i) begin
      cls.op = OP_TICK;
    end else if (chunk_end_i) begin
      cls.op = OP_BYTE_SCAN;
    end else begin
      cls.op = OP_BYTE;
    end
  end

  assign in_stall_o = (cnt_q == 2'd2);
  assign push       = in_valid_i && !in_stall_o;
  assign q_o.valid  = (cnt_q != 2'd0);
  assign q_o.cmd    = ent_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      ent_q[wp_q] <= cls;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) begin
        wp_q <= ~wp_q;
      end
      if (q_pop_i) begin
        rp_q <= ~rp_q;
      end
      case ({push, q_pop_i})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

FILE: hdl/lcf_back.sv
// Back end: byte FIFO, line scan with backspace editing, command emission.
// Depends on lcf_pkg and line_command_framer_macros.svh.
`include "line_command_framer_macros.svh"

module lcf_back import lcf_pkg::*; #(
  parameter int FIFO_DEPTH = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  qhead_t     q_i,
  output logic       q_pop_o,
  input  logic       out_stall_i,
  output logic       out_valid_o,
  output logic       kind_o,
  output logic [7:0] ch_o,
  output logic       last_o
);

  localparam int AW  = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int CW  = $clog2(FIFO_DEPTH + 1);
  localparam int WSW = CW + 1;

  logic [7:0] fifo_mem [FIFO_DEPTH];
  logic [7:0] line_mem [FIFO_DEPTH];
  logic [7:0] fm_rdata_q, lm_rdata_q;

  state_e        state_q, state_d;
  logic [AW-1:0] head_q, head_d;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] term_q, term_d;
  logic          sent_q, sent_d;
  logic          closed_q, closed_d;
  logic [CW-1:0] idx_q, idx_d;
  logic [CW-1:0] lend_q, lend_d;
  logic [AW-1:0] ptr_q, ptr_d;
  logic [AW-1:0] kept_q, kept_d;
  logic [AW-1:0] eidx_q, eidx_d;

  logic          out_valid_q;
  logic          out_kind_q, out_kind_d;
  logic [7:0]    out_ch_q, out_ch_d;
  logic          out_last_q, out_last_d;
  logic          out_load, out_free;

  logic          fm_we;
  logic [AW-1:0] fm_waddr;
  logic [WSW-1:0] wsum;
  logic          lm_we;
  logic [AW-1:0] lm_waddr;
  logic [7:0]    lm_wdata;
  logic [AW-1:0] ptr_inc;
  logic          emit_last;
  logic          ovf_beat;

  assign out_free = !out_valid_q || !out_stall_i;
  assign ptr_inc  = (ptr_q == AW'(FIFO_DEPTH - 1)) ? '0 : ptr_q + 1'b1;

  // tail slot = head + count, wrapped once
  assign wsum     = WSW'(head_q) + WSW'(count_q);
  assign fm_waddr = (wsum >= WSW'(FIFO_DEPTH)) ? AW'(wsum - WSW'(FIFO_DEPTH)) : AW'(wsum);

  assign emit_last = ((AW + 1)'(eidx_q) + 1'b1) == (AW + 1)'(kept_q);

  always_comb begin
    state_d    = state_q;
    head_d     = head_q;
    count_d    = count_q;
    term_d     = term_q;
    sent_d     = sent_q;
    closed_d   = closed_q;
    idx_d      = idx_q;
    lend_d     = lend_q;
    ptr_d      = ptr_q;
    kept_d     = kept_q;
    eidx_d     = eidx_q;
    q_pop_o    = 1'b0;
    fm_we      = 1'b0;
    lm_we      = 1'b0;
    lm_waddr   = kept_q;
    lm_wdata   = fm_rdata_q;
    out_load   = 1'b0;
    out_kind_d = KIND_CHAR;
    out_ch_d   = lm_rdata_q;
    out_last_d = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (q_i.valid) begin
          if (closed_q) begin
            q_pop_o = 1'b1;
          end else if (q_i.cmd.op == OP_TICK) begin
            q_pop_o = 1'b1;
            sent_d  = 1'b0;
            state_d = ST_CHECK;
          end else if (count_q == CW'(FIFO_DEPTH)) begin
            // full: one overflow notice, then closed for good
            if (out_free) begin
              q_pop_o    = 1'b1;
              out_load   = 1'b1;
              out_kind_d = KIND_OVERFLOW;
              out_ch_d   = '0;
              out_last_d = 1'b1;
              closed_d   = 1'b1;
            end
          end else begin
            q_pop_o = 1'b1;
            fm_we   = 1'b1;
            count_d = count_q + 1'b1;
            if (q_i.cmd.is_term) begin
              term_d = term_q + 1'b1;
            end
            if (q_i.cmd.op == OP_BYTE_SCAN) begin
              state_d = ST_CHECK;
            end
          end
        end
      end
      ST_CHECK: begin
        if (!sent_q && count_q != '0 && term_q != '0) begin
          idx_d   = '0;
          ptr_d   = head_q;
          kept_d  = '0;
          state_d = ST_SCAN_RD;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_SCAN_RD: begin
        state_d = ST_SCAN_EV;
      end
      ST_SCAN_EV: begin
        idx_d = idx_q + 1'b1;
        ptr_d = ptr_inc;
        if (is_term(fm_rdata_q)) begin
          lend_d = idx_q;
          if (kept_q == '0) begin
            lm_we    = 1'b1;
            lm_waddr = '0;
            lm_wdata = CH_SPACE;
            kept_d   = AW'(1);
          end
          state_d = ST_SKIP_RD;
        end else begin
          if (fm_rdata_q == CH_BS && kept_q != '0) begin
            kept_d = kept_q - 1'b1;
          end else if (fm_rdata_q >= CH_PRINT_LO && fm_rdata_q <= CH_PRINT_HI) begin
            lm_we  = 1'b1;
            kept_d = kept_q + 1'b1;
          end
          state_d = ST_SCAN_RD;
        end
      end
      ST_SKIP_RD: begin
        state_d = (idx_q == count_q) ? ST_FIN : ST_SKIP_EV;
      end
      ST_SKIP_EV: begin
        if (is_term(fm_rdata_q)) begin
          idx_d   = idx_q + 1'b1;
          ptr_d   = ptr_inc;
          state_d = ST_SKIP_RD;
        end else begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        head_d  = ptr_q;
        count_d = count_q - idx_q;
        term_d  = term_q - (idx_q - lend_q);
        sent_d  = 1'b1;
        eidx_d  = '0;
        state_d = ST_EMIT_RD;
      end
      ST_EMIT_RD: begin
        state_d = ST_EMIT_OUT;
      end
      ST_EMIT_OUT: begin
        if (out_free) begin
          out_load   = 1'b1;
          out_last_d = emit_last;
          if (emit_last) begin
            state_d = ST_IDLE;
          end else begin
            eidx_d  = eidx_q + 1'b1;
            state_d = ST_EMIT_RD;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (fm_we) begin
      fifo_mem[fm_waddr] <= q_i.cmd.data;
    end
    fm_rdata_q <= fifo_mem[ptr_q];
    if (lm_we) begin
      line_mem[lm_waddr] <= lm_wdata;
    end
    lm_rdata_q <= line_mem[eidx_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      head_q      <= '0;
      count_q     <= '0;
      term_q      <= '0;
      sent_q      <= 1'b0;
      closed_q    <= 1'b0;
      idx_q       <= '0;
      lend_q      <= '0;
      ptr_q       <= '0;
      kept_q      <= '0;
      eidx_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      head_q   <= head_d;
      count_q  <= count_d;
      term_q   <= term_d;
      sent_q   <= sent_d;
      closed_q <= closed_d;
      idx_q    <= idx_d;
      lend_q   <= lend_d;
      ptr_q    <= ptr_d;
      kept_q   <= kept_d;
      eidx_q   <= eidx_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_kind_q <= out_kind_d;
      out_ch_q   <= out_ch_d;
      out_last_q <= out_last_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign kind_o      = out_kind_q;
  assign ch_o        = out_ch_q;
  assign last_o      = out_last_q;

  assign ovf_beat = out_valid_q && (out_kind_q == KIND_OVERFLOW);

  `LCF_ASSERT_NOW(a_count_bound, 1'b1, count_q <= CW'(FIFO_DEPTH), "byte count above depth")
  `LCF_ASSERT_NOW(a_term_bound, 1'b1, term_q <= count_q, "terminator count above byte count")
  `LCF_ASSERT_NEXT(a_closed_sticky, closed_q, closed_q, "closed flag cleared")
  `LCF_ASSERT_NOW(a_overflow_beat, ovf_beat, out_last_q && out_ch_q == 8'h00, "bad overflow beat")
  `LCF_ASSERT_NOW(a_emit_range, state_q == ST_EMIT_OUT, eidx_q < kept_q, "emit index past line")

endmodule

FILE: tb/line_command_framer_checker.sv
// Scoreboard for the line command framer: watches both beat channels, keeps its own
// byte store and line editor, and compares every output beat. Depends on lcf_pkg.
`timescale 1ns / 100ps
package lcf_tb_pkg;

  localparam logic CMD_BYTE = 1'b0;
  localparam logic CMD_TICK = 1'b1;

endpackage

module line_command_framer_checker import lcf_pkg::*; import lcf_tb_pkg::*; #(
  parameter int FIFO_DEPTH = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_stall_i,
  input  logic       cmd_i,
  input  logic [7:0] data_i,
  input  logic       chunk_end_i,
  input  logic       out_valid_i,
  input  logic       out_stall_i,
  input  logic       kind_i,
  input  logic [7:0] ch_i,
  input  logic       last_i,
  output int         errors_o,
  output int         pending_o,
  output int         fifo_level_o,
  output int         commands_o,
  output int         checked_o,
  output logic       closed_o
);

  typedef struct packed {
    logic       kind;
    logic [7:0] ch;
    logic       last;
  } result_t;

  logic [7:0]  rx_bytes [FIFO_DEPTH];
  int unsigned rx_head    = 0;
  int unsigned rx_count   = 0;
  int unsigned eol_count  = 0;
  bit          pulse_used = 1'b0;
  bit          is_closed  = 1'b0;
  result_t     expected_q[$];
  result_t     want;
  int          mismatches = 0;
  int          commands   = 0;
  int          checked    = 0;

  function automatic bit is_eol(input logic [7:0] b);
    return (b == CH_CR) || (b == CH_LF);
  endfunction

  function automatic logic [7:0] rx_at(input int unsigned ofs);
    return rx_bytes[(rx_head + ofs) % FIFO_DEPTH];
  endfunction

  // Takes the oldest complete line out of the store, edits it and queues its characters.
  function automatic void release_command();
    int unsigned eol, pos, i, kept;
    logic [7:0]  b;
    logic [7:0]  line_buf [FIFO_DEPTH];
    result_t     r;
    if (pulse_used || rx_count == 0 || eol_count == 0) return;
    eol = 0;
    while (eol < rx_count && !is_eol(rx_at(eol))) eol++;
    if (eol >= rx_count) return;
    kept = 0;
    for (i = 0; i < eol; i++) begin
      b = rx_at(i);
      if (b == CH_BS && kept != 0) kept--;
      else if (b >= CH_PRINT_LO && b <= CH_PRINT_HI) begin
        line_buf[kept] = b;
        kept++;
      end
    end
    if (kept == 0) begin
      line_buf[0] = CH_SPACE;
      kept = 1;
    end
    // drop the terminator run, but never past the newest byte
    pos = eol;
    while (pos < rx_count && is_eol(rx_at(pos))) pos++;
    eol_count -= pos - eol;
    rx_head = (rx_head + pos) % FIFO_DEPTH;
    rx_count -= pos;
    pulse_used = 1'b1;
    commands++;
    for (i = 0; i < kept; i++) begin
      r.kind = KIND_CHAR;
      r.ch   = line_buf[i];
      r.last = (i + 1 == kept);
      expected_q.insert(expected_q.size(), r);
    end
  endfunction

  function automatic void take_beat(input logic cmd, input logic [7:0] data,
                                    input logic chunk_end);
    result_t r;
    if (is_closed) return;
    if (cmd == CMD_TICK) begin
      pulse_used = 1'b0;
      release_command();
    end else if (rx_count >= FIFO_DEPTH) begin
      is_closed = 1'b1;
      r.kind = KIND_OVERFLOW;
      r.ch   = '0;
      r.last = 1'b1;
      expected_q.insert(expected_q.size(), r);
    end else begin
      rx_bytes[(rx_head + rx_count) % FIFO_DEPTH] = data;
      rx_count++;
      if (is_eol(data)) eol_count++;
      if (chunk_end) release_command();
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rx_head    = 0;
      rx_count   = 0;
      eol_count  = 0;
      pulse_used = 1'b0;
      is_closed  = 1'b0;
      expected_q.delete();
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_q.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result beat: expected none, got kind=%0d ch=%02h last=%0d",
                   $time, kind_i, ch_i, last_i);
        end else begin
          want = expected_q.pop_front();
          checked++;
          if (kind_i !== want.kind || ch_i !== want.ch || last_i !== want.last) begin
            mismatches++;
            $display("%0t: result mismatch: expected kind=%0d ch=%02h last=%0d, got %s",
                     $time, want.kind, want.ch, want.last,
                     $sformatf("kind=%0d ch=%02h last=%0d", kind_i, ch_i, last_i));
          end
        end
      end
      if (in_valid_i && !in_stall_i) take_beat(cmd_i, data_i, chunk_end_i);
    end
    errors_o     <= mismatches;
    pending_o    <= expected_q.size();
    fifo_level_o <= rx_count;
    commands_o   <= commands;
    checked_o    <= checked;
    closed_o     <= is_closed;
  end

endmodule

FILE: tb/tb_line_command_framer.sv
// Testbench top for the line command framer: clock, reset, beat stimulus and verdict.
// Depends on lcf_pkg, lcf_tb_pkg, line_command_framer and line_command_framer_checker.
`timescale 1ns / 100ps
module tb_line_command_framer;
  import lcf_pkg::*;
  import lcf_tb_pkg::*;

  localparam int FIFO_DEPTH   = 64;
  localparam int RANDOM_BEATS = 370;
  localparam int HOLD_CYCLES  = 400;
  localparam int IDLE_PCT     = 14;

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_stall_o;
  logic       cmd_i;
  logic [7:0] data_i;
  logic       chunk_end_i;
  logic       out_valid_o;
  logic       out_stall_i;
  logic       kind_o;
  logic [7:0] ch_o;
  logic       last_o;

  int   errors;
  int   pending;
  int   fifo_level;
  int   commands;
  int   checked;
  logic closed;
  bit   calm;
  bit   hold_req;
  int   beats_sent = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  line_command_framer #(.FIFO_DEPTH(FIFO_DEPTH)) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .cmd_i      (cmd_i),
    .data_i     (data_i),
    .chunk_end_i(chunk_end_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .kind_o     (kind_o),
    .ch_o       (ch_o),
    .last_o     (last_o)
  );

  line_command_framer_checker #(.FIFO_DEPTH(FIFO_DEPTH)) u_check (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_i  (in_stall_o),
    .cmd_i       (cmd_i),
    .data_i      (data_i),
    .chunk_end_i (chunk_end_i),
    .out_valid_i (out_valid_o),
    .out_stall_i (out_stall_i),
    .kind_i      (kind_o),
    .ch_i        (ch_o),
    .last_i      (last_o),
    .errors_o    (errors),
    .pending_o   (pending),
    .fifo_level_o(fifo_level),
    .commands_o  (commands),
    .checked_o   (checked),
    .closed_o    (closed)
  );

  // Holds the beat until accepted; returns at the accepting edge.
  task automatic send_beat(input logic cmd, input logic [7:0] data, input logic chunk_end);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    cmd_i       <= cmd;
    data_i      <= data;
    chunk_end_i <= chunk_end;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    beats_sent++;
  endtask

  task automatic send_tick();
    logic [7:0] junk;
    junk = 8'($urandom_range(255));
    send_beat(CMD_TICK, junk, 1'($urandom_range(1)));
  endtask

  function automatic logic [7:0] line_char();
    int         r;
    logic [7:0] b;
    r = $urandom_range(99);
    if (r < 65) b = 8'($urandom_range(CH_PRINT_HI, CH_PRINT_LO));
    else if (r < 80) b = CH_BS;
    else b = 8'($urandom_range(255));
    return b;
  endfunction

  // fifo_level lags by at most one beat, hence the margin
  task automatic make_room(input int need);
    int tries;
    tries = 0;
    while (fifo_level + need + 4 > FIFO_DEPTH) begin
      if (tries % 4 == 3) send_beat(CMD_BYTE, CH_LF, 1'b0);
      else send_beat(CMD_TICK, 8'h00, 1'b0);
      tries++;
    end
  endtask

  task automatic send_line(input int len);
    int         n_eol, i;
    logic [7:0] b;
    n_eol = $urandom_range(3, 1);
    make_room(len + n_eol);
    for (i = 0; i < len; i++) begin
      if ($urandom_range(99) < 4) send_tick();
      send_beat(CMD_BYTE, line_char(), $urandom_range(99) < 8);
    end
    for (i = 0; i < n_eol; i++) begin
      b = $urandom_range(1) ? CH_CR : CH_LF;
      send_beat(CMD_BYTE, b, (i == n_eol - 1) ? ($urandom_range(99) < 75)
                                              : ($urandom_range(99) < 10));
    end
  endtask

  task automatic wait_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    wait (pending == 0);
    @(posedge clk_i);
  endtask

  // Closes any partial line, then ticks until the store is empty.
  task automatic drain_store();
    send_beat(CMD_BYTE, CH_LF, 1'b0);
    do begin
      send_beat(CMD_TICK, 8'h00, 1'b0);
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end while (fifo_level != 0);
  endtask

  // Receiver: random stalls, one long hold-off on request
  initial begin
    bit hold_taken;
    hold_taken  = 1'b0;
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else begin
        out_stall_i <= !calm && ($urandom_range(99) < IDLE_PCT);
      end
    end
  end

  initial begin
    int         i, r, start;
    bit         paused, held;
    logic [7:0] b;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    cmd_i       = CMD_BYTE;
    data_i      = 8'h00;
    chunk_end_i = 1'b0;
    calm        = 1'b0;
    hold_req    = 1'b0;
    paused      = 1'b0;
    held        = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // chunk ends before any terminator: nothing to release
    send_beat(CMD_BYTE, "a", 1'b0);
    send_beat(CMD_BYTE, "b", 1'b0);
    send_beat(CMD_BYTE, "c", 1'b1);
    // backspace edit, released on chunk end
    send_beat(CMD_BYTE, CH_BS, 1'b0);
    send_beat(CMD_BYTE, CH_LF, 1'b1);
    // second line in the same pulse waits for the next tick
    send_beat(CMD_BYTE, "x", 1'b0);
    send_beat(CMD_BYTE, CH_CR, 1'b1);
    send_beat(CMD_TICK, 8'hFF, 1'b1);
    send_beat(CMD_TICK, 8'h00, 1'b0);
    // leading backspace and unprintables only: comes out as one space
    send_beat(CMD_BYTE, CH_BS, 1'b0);
    send_beat(CMD_BYTE, 8'h00, 1'b0);
    send_beat(CMD_BYTE, 8'h7F, 1'b0);
    send_beat(CMD_BYTE, 8'hFF, 1'b0);
    send_beat(CMD_BYTE, 8'h1F, 1'b0);
    send_beat(CMD_BYTE, CH_LF, 1'b0);
    send_beat(CMD_BYTE, CH_CR, 1'b0);
    send_beat(CMD_BYTE, CH_LF, 1'b1);
    // printable range ends, terminators at the very end of the store
    send_beat(CMD_TICK, 8'h00, 1'b0);
    send_beat(CMD_BYTE, CH_PRINT_HI, 1'b0);
    send_beat(CMD_BYTE, CH_PRINT_LO, 1'b0);
    send_beat(CMD_BYTE, CH_CR, 1'b0);
    send_beat(CMD_BYTE, CH_LF, 1'b0);
    send_beat(CMD_TICK, 8'h00, 1'b0);
    wait_results();

    start = beats_sent;
    while (beats_sent - start < RANDOM_BEATS) begin
      calm <= (beats_sent - start >= 260) && (beats_sent - start < 340);
      if (!paused && beats_sent - start >= 120) begin
        paused = 1'b1;
        wait_results();
      end
      if (!held && beats_sent - start >= 200) begin
        // full store of one line, output held off while input keeps coming
        held = 1'b1;
        drain_store();
        send_beat(CMD_TICK, 8'h00, 1'b0);
        hold_req <= 1'b1;
        for (i = 0; i < FIFO_DEPTH - 1; i++) begin
          b = 8'($urandom_range(CH_PRINT_HI, CH_PRINT_LO));
          send_beat(CMD_BYTE, b, 1'b0);
        end
        send_beat(CMD_BYTE, CH_LF, 1'b1);
      end
      r = $urandom_range(99);
      if (r < 55) send_line(($urandom_range(99) < 80) ? $urandom_range(8)
                                                      : $urandom_range(30, 9));
      else if (r < 85) send_tick();
      else if (r < 88) send_line($urandom_range(56, 40));
      else begin
        make_room(6);
        repeat ($urandom_range(6, 1)) begin
          b = 8'($urandom_range(255));
          send_beat(CMD_BYTE, b, 1'($urandom_range(1)));
        end
      end
    end
    calm <= 1'b0;

    // overflow: store full with a line in it, overflowing byte marks a chunk end
    drain_store();
    send_beat(CMD_TICK, 8'h00, 1'b0);
    for (i = 0; i < FIFO_DEPTH - 1; i++) begin
      b = 8'($urandom_range(CH_PRINT_HI, CH_PRINT_LO));
      send_beat(CMD_BYTE, b, 1'b0);
    end
    send_beat(CMD_BYTE, CH_LF, 1'b0);
    send_beat(CMD_BYTE, "Z", 1'b1);
    // closed from here on
    send_beat(CMD_TICK, 8'h00, 1'b0);
    send_beat(CMD_BYTE, CH_LF, 1'b1);
    send_beat(CMD_TICK, 8'h00, 1'b0);

    in_valid_i <= 1'b0;
    @(posedge clk_i);
    wait (pending == 0);
    repeat (300) @(posedge clk_i);

    $display("Run covered %0d input beats, %0d commands released, %0d result beats compared.",
             beats_sent, commands, checked);
    $display("Store overflow and close-down %s.", closed ? "exercised" : "not reached");
    if (errors == 0 && pending == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

  initial begin
    #15_000_000;
    $display("%0t: timeout with %0d result beats still owed", $time, pending);
    $display("DONE: errors detected");
    $finish;
  end

endmodule
